### rtl/core/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and constants of the biquad coefficient calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

  localparam int FX     = 30;
  localparam int W0W    = 30;
  localparam int TW     = 31;
  localparam int A0W    = 38;
  localparam int NUMW   = 39;
  localparam int MAGW   = 38;
  localparam int ALW    = 37;
  localparam int QEW    = 16;
  localparam int FREQW  = 16;
  localparam int COEF_W = 20;
  localparam int QBITS  = COEF_W + 1;
  localparam int NCOEF  = 5;
  localparam int NSTEP  = 6;
  localparam int NLANE  = 2;
  localparam int LANE_SIN = 0;
  localparam int LANE_COS = 1;

  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [TW-1:0]    ONE      = 31'h4000_0000;
  localparam logic [TW-1:0]    PI_HALF  = 31'd1686629713;
  localparam logic [FREQW-1:0] FREQ_MAX = 16'd32768;
  localparam logic [15:0]      W0_RND   = 16'd32768;

  localparam longint RECIP_NUM = 64'h4000_0000;

  localparam logic [7:0] DIV_K [NLANE][NSTEP] = '{
    '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6},
    '{8'd132, 8'd90,  8'd56, 8'd30, 8'd12, 8'd2}
  };

  localparam logic [W0W-1:0] DIV_M [NLANE][NSTEP] = '{
    '{W0W'(RECIP_NUM / 156), W0W'(RECIP_NUM / 110), W0W'(RECIP_NUM / 72),
      W0W'(RECIP_NUM / 42),  W0W'(RECIP_NUM / 20),  W0W'(RECIP_NUM / 6)},
    '{W0W'(RECIP_NUM / 132), W0W'(RECIP_NUM / 90),  W0W'(RECIP_NUM / 56),
      W0W'(RECIP_NUM / 30),  W0W'(RECIP_NUM / 12),  W0W'(RECIP_NUM / 2)}
  };

  localparam logic [QBITS-1:0]  SAT_POS  = QBITS'((64'd1 << (COEF_W - 1)) - 1);
  localparam logic [QBITS-1:0]  SAT_NEG  = QBITS'(64'd1 << (COEF_W - 1));
  localparam logic [COEF_W-1:0] COEF_MAX = COEF_W'((64'd1 << (COEF_W - 1)) - 1);
  localparam logic [COEF_W-1:0] COEF_MIN = COEF_W'(64'd1 << (COEF_W - 1));

  typedef enum logic [1:0] {
    KIND_LP = 2'd0,
    KIND_HP = 2'd1,
    KIND_BP = 2'd2,
    KIND_BS = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [FREQW-1:0]  freq;
    logic [QEW-1:0]    qe;
  } req_t;

  typedef struct packed {
    kind_t           kind;
    logic [QEW-1:0]  qe;
  } tside_t;

  typedef struct packed {
    kind_t           kind;
    logic [W0W-1:0]  s;
    logic [TW-1:0]   c;
  } aside_t;

endpackage

`default_nettype wire

### rtl/core/bqc_front.sv
// ----------------------------------------------------------------------------
// bqc_front
// Accepts request items, clamps frequency and q, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  kind,
  input  logic [bqc_pkg::FREQW-1:0]   freq,
  input  logic [bqc_pkg::QEW-1:0]     q,
  input  logic                        pop,
  output logic                        avail,
  output bqc_pkg::req_t               head
);

  bqc_pkg::req_t               mem [bqc_pkg::QDEPTH];
  bqc_pkg::req_t               item;
  logic [bqc_pkg::QPW-1:0]     wptr;
  logic [bqc_pkg::QPW-1:0]     rptr;
  logic [bqc_pkg::QCW-1:0]     count;
  logic                        full;
  logic                        push;

  assign full      = count == bqc_pkg::QCW'(bqc_pkg::QDEPTH);
  assign req_ready = !full;
  assign push      = req_valid && !full;
  assign avail     = count != '0;
  assign head      = mem[rptr];

  always_comb begin
    item.kind = bqc_pkg::kind_t'(kind);
    item.freq = (freq > bqc_pkg::FREQ_MAX) ? bqc_pkg::FREQ_MAX : freq;
    item.qe   = (q == '0) ? bqc_pkg::QEW'(1) : q;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + bqc_pkg::QCW'(push) - bqc_pkg::QCW'(pop);
    end
  end

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("queue popped while empty");
  a_push_pop_level: assert property (@(posedge clk) disable iff (rst)
    (push && pop) |=> count == $past(count))
    else $error("queue level moved on simultaneous push and pop");

endmodule

`default_nettype wire

### rtl/core/bqc_trig.sv
// ----------------------------------------------------------------------------
// bqc_trig
// Pipelined angle, sine, cosine by Horner series; one item per cycle while en.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_trig #(
  parameter int SW = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bqc_pkg::FREQW-1:0]   in_freq,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [bqc_pkg::W0W-1:0]     out_sin,
  output logic [bqc_pkg::TW-1:0]      out_cos,
  output logic [SW-1:0]               out_side
);

  localparam int NS = bqc_pkg::NSTEP;
  localparam int NL = bqc_pkg::NLANE;

  logic [46:0]               prod0;
  logic [59:0]               sq1;
  logic                      e0_v, e1_v;
  logic [bqc_pkg::W0W-1:0]   e0_w0, e1_w0, e1_x2;
  logic [SW-1:0]             e0_side, e1_side;

  logic                      si_v    [NS];
  logic [bqc_pkg::W0W-1:0]   si_w0   [NS];
  logic [bqc_pkg::W0W-1:0]   si_x2   [NS];
  logic [SW-1:0]             si_side [NS];
  logic [bqc_pkg::TW-1:0]    si_t    [NL][NS];

  logic                      a_v [NS], b_v [NS], c_v [NS];
  logic [bqc_pkg::W0W-1:0]   a_w0 [NS], b_w0 [NS], c_w0 [NS];
  logic [bqc_pkg::W0W-1:0]   a_x2 [NS], b_x2 [NS], c_x2 [NS];
  logic [SW-1:0]             a_side [NS], b_side [NS], c_side [NS];
  logic [bqc_pkg::W0W-1:0]   a_p [NL][NS];
  logic [bqc_pkg::W0W-1:0]   b_p [NL][NS];
  logic [bqc_pkg::W0W-1:0]   b_q [NL][NS];
  logic [bqc_pkg::TW-1:0]    c_t [NL][NS];

  logic [60:0]               mul_a [NL][NS];
  logic [59:0]               mul_b [NL][NS];
  logic [37:0]               qk    [NL][NS];
  logic [bqc_pkg::W0W-1:0]   rr    [NL][NS];
  logic [bqc_pkg::W0W-1:0]   qf    [NL][NS];
  logic [60:0]               mul_f;

  assign prod0 = 47'(in_freq) * 47'(bqc_pkg::PI_HALF) + 47'(bqc_pkg::W0_RND);
  assign sq1   = 60'(e0_w0) * 60'(e0_w0);
  assign mul_f = 61'(c_w0[NS-1]) * 61'(c_t[bqc_pkg::LANE_SIN][NS-1]);

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (i == 0) begin
        si_v[i]    = e1_v;
        si_w0[i]   = e1_w0;
        si_x2[i]   = e1_x2;
        si_side[i] = e1_side;
        for (int l = 0; l < NL; l++) begin
          si_t[l][i] = bqc_pkg::ONE;
        end
      end else begin
        si_v[i]    = c_v[i-1];
        si_w0[i]   = c_w0[i-1];
        si_x2[i]   = c_x2[i-1];
        si_side[i] = c_side[i-1];
        for (int l = 0; l < NL; l++) begin
          si_t[l][i] = c_t[l][i-1];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      for (int i = 0; i < NS; i++) begin
        mul_a[l][i] = 61'(si_x2[i]) * 61'(si_t[l][i]);
        mul_b[l][i] = 60'(a_p[l][i]) * 60'(bqc_pkg::DIV_M[l][i]);
        qk[l][i]    = 38'(b_q[l][i]) * 38'(bqc_pkg::DIV_K[l][i]);
        rr[l][i]    = b_p[l][i] - qk[l][i][bqc_pkg::W0W-1:0];
        qf[l][i]    = b_q[l][i]
                    + bqc_pkg::W0W'(rr[l][i] >= bqc_pkg::W0W'(bqc_pkg::DIV_K[l][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e0_v      <= 1'b0;
      e1_v      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        a_v[i] <= 1'b0;
        b_v[i] <= 1'b0;
        c_v[i] <= 1'b0;
      end
    end else if (en) begin
      e0_v      <= in_valid;
      e1_v      <= e0_v;
      out_valid <= c_v[NS-1];
      for (int i = 0; i < NS; i++) begin
        a_v[i] <= si_v[i];
        b_v[i] <= a_v[i];
        c_v[i] <= b_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_w0   <= prod0[45:16];
      e0_side <= in_side;
      e1_w0   <= e0_w0;
      e1_x2   <= sq1[59:30];
      e1_side <= e0_side;
      for (int i = 0; i < NS; i++) begin
        a_w0[i]   <= si_w0[i];
        a_x2[i]   <= si_x2[i];
        a_side[i] <= si_side[i];
        b_w0[i]   <= a_w0[i];
        b_x2[i]   <= a_x2[i];
        b_side[i] <= a_side[i];
        c_w0[i]   <= b_w0[i];
        c_x2[i]   <= b_x2[i];
        c_side[i] <= b_side[i];
        for (int l = 0; l < NL; l++) begin
          a_p[l][i] <= mul_a[l][i][59:30];
          b_p[l][i] <= a_p[l][i];
          b_q[l][i] <= mul_b[l][i][59:30];
          c_t[l][i] <= bqc_pkg::ONE - bqc_pkg::TW'(qf[l][i]);
        end
      end
      out_sin  <= mul_f[59:30];
      out_cos  <= c_t[bqc_pkg::LANE_COS][NS-1];
      out_side <= c_side[NS-1];
    end
  end

  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_cos <= bqc_pkg::ONE)
    else $error("cosine above one");

endmodule

`default_nettype wire

### rtl/core/bqc_div.sv
// ----------------------------------------------------------------------------
// bqc_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_div #(
  parameter int DW = 37,
  parameter int VW = 16,
  parameter int QW = 37,
  parameter int SW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DW-1:0]  dividend,
  input  logic [VW-1:0]  divisor,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [QW-1:0]  quotient,
  output logic           overflow,
  output logic [SW-1:0]  out_side
);

  localparam int RW = (DW > VW + QW) ? DW : VW + QW;

  logic           v    [QW+1];
  logic [RW-1:0]  rem  [QW+1];
  logic [VW-1:0]  dv   [QW+1];
  logic [QW-1:0]  quo  [QW+1];
  logic           ovf  [QW+1];
  logic [SW-1:0]  side [QW+1];
  logic [RW-1:0]  trial [QW];
  logic           ge    [QW];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      trial[j] = RW'(dv[j]) << (QW - 1 - j);
      ge[j]    = rem[j] >= trial[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QW; j++) begin
        v[j] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= in_valid;
      for (int j = 0; j < QW; j++) begin
        v[j+1] <= v[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= RW'(dividend);
      dv[0]   <= divisor;
      quo[0]  <= '0;
      ovf[0]  <= RW'(dividend) >= (RW'(divisor) << QW);
      side[0] <= in_side;
      for (int j = 0; j < QW; j++) begin
        rem[j+1]  <= ge[j] ? rem[j] - trial[j] : rem[j];
        dv[j+1]   <= dv[j];
        quo[j+1]  <= {quo[j][QW-2:0], ge[j]};
        ovf[j+1]  <= ovf[j];
        side[j+1] <= side[j];
      end
    end
  end

  assign out_valid = v[QW];
  assign quotient  = quo[QW];
  assign overflow  = ovf[QW];
  assign out_side  = side[QW];

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !overflow) |-> rem[QW] < RW'(dv[QW]))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

### rtl/core/biquad_coefficient_calculator.sv
// ----------------------------------------------------------------------------
// biquad_coefficient_calculator
// Normalized biquad coefficients from filter kind, frequency and q.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    kind, freq, q
//   coef     out  coef_valid/coef_ready  coef_b0, coef_b1, coef_b2, coef_a1, coef_a2
//
// One item per cycle sustained while results are taken; a request passes the
// 21-stage sine/cosine pipeline, the 38-stage alpha divider, two numerator
// stages, the 22-stage coefficient dividers and the output register.
// A four-entry queue takes requests while the back end is stalled. Reset is
// synchronous and clears all valid bits.
// The back end holds as a whole while a result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_coefficient_calculator #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [1:0]                        kind,
  input  logic [bqc_pkg::FREQW-1:0]         freq,
  input  logic [bqc_pkg::QEW-1:0]           q,
  output logic                              coef_valid,
  input  logic                              coef_ready,
  output logic signed [bqc_pkg::COEF_W-1:0] coef_b0,
  output logic signed [bqc_pkg::COEF_W-1:0] coef_b1,
  output logic signed [bqc_pkg::COEF_W-1:0] coef_b2,
  output logic signed [bqc_pkg::COEF_W-1:0] coef_a1,
  output logic signed [bqc_pkg::COEF_W-1:0] coef_a2
);

  localparam int NC  = bqc_pkg::NCOEF;
  localparam int DVW = bqc_pkg::MAGW + COEF_FRAC_BITS + 1;

  logic                          adv;
  logic                          pop;
  logic                          avail;
  bqc_pkg::req_t                 head;
  bqc_pkg::tside_t               t_in_side;
  bqc_pkg::tside_t               t_side;
  logic                          t_v;
  logic [bqc_pkg::W0W-1:0]       t_sin;
  logic [bqc_pkg::TW-1:0]        t_cos;
  bqc_pkg::aside_t               a_in_side;
  bqc_pkg::aside_t               a_side;
  logic                          a_v;
  logic [bqc_pkg::ALW-1:0]       alpha;
  logic                          a_ovf;

  logic signed [bqc_pkg::NUMW-1:0] cs, ss, os, as;
  logic signed [bqc_pkg::NUMW-1:0] num [NC];

  logic                          n1_v;
  logic [bqc_pkg::A0W-1:0]       n1_a0;
  logic signed [bqc_pkg::NUMW-1:0] n1_num [NC];
  logic                          n2_v;
  logic [bqc_pkg::A0W-1:0]       n2_a0;
  logic                          n2_neg [NC];
  logic [DVW-1:0]                n2_div [NC];
  logic [bqc_pkg::NUMW-1:0]      absv   [NC];

  logic [NC-1:0]                 c_vld;
  logic [bqc_pkg::QBITS-1:0]     cq   [NC];
  logic                          covf [NC];
  logic                          cneg [NC];
  logic [bqc_pkg::COEF_W-1:0]    sat  [NC];

  assign adv = !coef_valid || coef_ready;
  assign pop = adv && avail;

  bqc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .freq      (freq),
    .q         (q),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  always_comb begin
    t_in_side.kind = head.kind;
    t_in_side.qe   = head.qe;
  end

  bqc_trig #(
    .SW ($bits(bqc_pkg::tside_t))
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (avail),
    .in_freq   (head.freq),
    .in_side   (t_in_side),
    .out_valid (t_v),
    .out_sin   (t_sin),
    .out_cos   (t_cos),
    .out_side  (t_side)
  );

  always_comb begin
    a_in_side.kind = t_side.kind;
    a_in_side.s    = t_sin;
    a_in_side.c    = t_cos;
  end

  bqc_div #(
    .DW (bqc_pkg::ALW),
    .VW (bqc_pkg::QEW),
    .QW (bqc_pkg::ALW),
    .SW ($bits(bqc_pkg::aside_t))
  ) u_alpha_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (t_v),
    .dividend  ({t_sin, 7'b0}),
    .divisor   (t_side.qe),
    .in_side   (a_in_side),
    .out_valid (a_v),
    .quotient  (alpha),
    .overflow  (a_ovf),
    .out_side  (a_side)
  );

  always_comb begin
    cs = bqc_pkg::NUMW'(a_side.c);
    ss = bqc_pkg::NUMW'(a_side.s);
    os = bqc_pkg::NUMW'(bqc_pkg::ONE);
    as = bqc_pkg::NUMW'(alpha);
    unique case (a_side.kind)
      bqc_pkg::KIND_LP: begin
        num[0] = (os - cs) >>> 1;
        num[1] = os - cs;
        num[2] = (os - cs) >>> 1;
      end
      bqc_pkg::KIND_HP: begin
        num[0] = (os + cs) >>> 1;
        num[1] = -(os + cs);
        num[2] = (os + cs) >>> 1;
      end
      bqc_pkg::KIND_BP: begin
        num[0] = ss >>> 1;
        num[1] = '0;
        num[2] = -(ss >>> 1);
      end
      bqc_pkg::KIND_BS: begin
        num[0] = os;
        num[1] = -(cs <<< 1);
        num[2] = os;
      end
    endcase
    num[3] = -(cs <<< 1);
    num[4] = os - as;
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      absv[k] = n1_num[k][bqc_pkg::NUMW-1] ? bqc_pkg::NUMW'(-n1_num[k]) : n1_num[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
    end else if (adv) begin
      n1_v <= a_v;
      n2_v <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_a0 <= bqc_pkg::A0W'(bqc_pkg::ONE) + bqc_pkg::A0W'(alpha);
      n2_a0 <= n1_a0;
      for (int k = 0; k < NC; k++) begin
        n1_num[k] <= num[k];
        n2_neg[k] <= n1_num[k][bqc_pkg::NUMW-1];
        n2_div[k] <= (DVW'(absv[k][bqc_pkg::MAGW-1:0]) << COEF_FRAC_BITS)
                   + DVW'(n1_a0 >> 1);
      end
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_coef
    bqc_div #(
      .DW (DVW),
      .VW (bqc_pkg::A0W),
      .QW (bqc_pkg::QBITS),
      .SW (1)
    ) u_coef_div (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (n2_v),
      .dividend  (n2_div[k]),
      .divisor   (n2_a0),
      .in_side   (n2_neg[k]),
      .out_valid (c_vld[k]),
      .quotient  (cq[k]),
      .overflow  (covf[k]),
      .out_side  (cneg[k])
    );
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (cneg[k]) begin
        sat[k] = (covf[k] || cq[k] > bqc_pkg::SAT_NEG) ? bqc_pkg::COEF_MIN
               : bqc_pkg::COEF_W'(-cq[k]);
      end else begin
        sat[k] = (covf[k] || cq[k] > bqc_pkg::SAT_POS) ? bqc_pkg::COEF_MAX
               : cq[k][bqc_pkg::COEF_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (adv) begin
      coef_valid <= c_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_vld[0]) begin
      coef_b0 <= sat[0];
      coef_b1 <= sat[1];
      coef_b2 <= sat[2];
      coef_a1 <= sat[3];
      coef_a2 <= sat[4];
    end
  end

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    c_vld == '0 || c_vld == '1)
    else $error("coefficient lanes out of step");
  a_alpha_no_ovf: assert property (@(posedge clk) disable iff (rst)
    a_v |-> !a_ovf)
    else $error("alpha quotient overflow");

endmodule

`default_nettype wire

### verif/biquad_coefficient_calculator_tb.sv
// ----------------------------------------------------------------------------
// biquad_coefficient_calculator_tb
// Drives requests of every filter kind, over chosen frequencies and q, through
// the valid/ready channel, computes the fixed-point coefficients in the bench
// and compares each result item with the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_coefficient_calculator_tb;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 20000;
  localparam longint UNIT = 64'd1 << 30;

  typedef struct {
    logic signed [bqc_pkg::COEF_W-1:0] c [bqc_pkg::NCOEF];
  } coef_set_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  logic [1:0] kind;
  logic [bqc_pkg::FREQW-1:0] freq;
  logic [bqc_pkg::QEW-1:0] q;
  logic coef_valid;
  logic coef_ready;
  logic signed [bqc_pkg::COEF_W-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  coef_set_t pending_coefs[$];
  int errors;
  int results_seen;
  int sent;
  int idle_pct;
  int stall_cycles;
  bit timed_out;

  biquad_coefficient_calculator #(.COEF_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .kind(kind), .freq(freq), .q(q),
    .coef_valid(coef_valid), .coef_ready(coef_ready),
    .coef_b0(coef_b0), .coef_b1(coef_b1), .coef_b2(coef_b2),
    .coef_a1(coef_a1), .coef_a2(coef_a2)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint taylor_poly(longint sq, bit is_cos);
    longint t;
    t = UNIT;
    for (int i = 0; i < bqc_pkg::NSTEP; i++) begin
      t = UNIT - ((sq * t) >>> 30)
        / longint'(is_cos ? bqc_pkg::DIV_K[bqc_pkg::LANE_COS][i]
                          : bqc_pkg::DIV_K[bqc_pkg::LANE_SIN][i]);
    end
    return t;
  endfunction

  function automatic logic signed [bqc_pkg::COEF_W-1:0] scale_coef(longint num, longint den);
    bit neg;
    longint mag, quo;
    neg = num < 0;
    mag = neg ? -num : num;
    quo = ((mag <<< FRAC) + den / 2) / den;
    if (neg) return (quo > 524288) ? bqc_pkg::COEF_MIN : bqc_pkg::COEF_W'(-quo);
    return (quo > 524287) ? bqc_pkg::COEF_MAX : bqc_pkg::COEF_W'(quo);
  endfunction

  function automatic coef_set_t biquad_coefs(bqc_pkg::kind_t k, logic [15:0] f,
                                             logic [15:0] qv);
    longint fc, qe, w0, sq, s, c, alpha, den;
    longint b0, b1, b2;
    coef_set_t r;
    fc = (f > 16'd32768) ? 32768 : longint'(f);
    qe = (qv == 0) ? 1 : longint'(qv);
    w0 = (fc * 64'd1686629713 + 32768) >>> 16;
    sq = (w0 * w0) >>> 30;
    s = (w0 * taylor_poly(sq, 1'b0)) >>> 30;
    c = taylor_poly(sq, 1'b1);
    alpha = (s * 128) / qe;
    den = UNIT + alpha;
    case (k)
      bqc_pkg::KIND_LP: begin b0 = (UNIT - c) / 2; b1 = UNIT - c; b2 = b0; end
      bqc_pkg::KIND_HP: begin b0 = (UNIT + c) / 2; b1 = -(UNIT + c); b2 = b0; end
      bqc_pkg::KIND_BP: begin b0 = s / 2; b1 = 0; b2 = -b0; end
      default: begin b0 = UNIT; b1 = -2 * c; b2 = UNIT; end
    endcase
    r.c[0] = scale_coef(b0, den);
    r.c[1] = scale_coef(b1, den);
    r.c[2] = scale_coef(b2, den);
    r.c[3] = scale_coef(-2 * c, den);
    r.c[4] = scale_coef(UNIT - alpha, den);
    return r;
  endfunction

  // result checker and output-side stalls
  always @(posedge clk) begin
    coef_set_t exp_set;
    logic signed [bqc_pkg::COEF_W-1:0] got [bqc_pkg::NCOEF];
    if (rst) begin
      coef_ready <= 1'b0;
    end else begin
      if (coef_valid && coef_ready) begin
        got = '{coef_b0, coef_b1, coef_b2, coef_a1, coef_a2};
        results_seen++;
        if (pending_coefs.size() == 0) begin
          $display("%0t: unexpected result item b0=%0d", $time, coef_b0);
          errors++;
        end else begin
          exp_set = pending_coefs.pop_front();
          for (int i = 0; i < bqc_pkg::NCOEF; i++) begin
            if (got[i] !== exp_set.c[i]) begin
              $display("%0t: coef %0d expected %0d actual %0d", $time, i, exp_set.c[i],
                       got[i]);
              errors++;
            end
          end
        end
      end
      coef_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (coef_valid && coef_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("biquad_coefficient_calculator_tb failed");
        $finish;
      end
    end
  end

  task automatic send_item(bqc_pkg::kind_t k, logic [15:0] f, logic [15:0] qv);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind <= k;
    freq <= f;
    q <= qv;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pending_coefs.push_back(biquad_coefs(k, f, qv));
    sent++;
  endtask

  task automatic test_directed();
    logic [15:0] fv [6] = '{16'd0, 16'd1, 16'd16384, 16'd32768, 16'd32769, 16'hffff};
    logic [15:0] qv [5] = '{16'd0, 16'd1, 16'd181, 16'd256, 16'hffff};
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 6; i++) send_item(bqc_pkg::kind_t'(k), fv[i], qv[i % 5]);
    end
    send_item(bqc_pkg::KIND_BS, 16'h5555, 16'haaaa);
  endtask

  task automatic test_random(int n);
    logic [15:0] f, qv;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32768));
      qv = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(32, 2560));
      send_item(bqc_pkg::kind_t'($urandom_range(3)), f, qv);
    end
  endtask

  task automatic test_back_to_back(int n);
    idle_pct = 0;
    test_random(n);
    idle_pct = 17;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    kind = '0;
    freq = '0;
    q = '0;
    coef_ready = 1'b0;
    errors = 0;
    results_seen = 0;
    sent = 0;
    idle_pct = 17;
    stall_cycles = 0;
    timed_out = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_back_to_back(120);
    test_random(105);
    req_valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d requests over all four filter kinds, checked %0d coefficient sets",
             sent, results_seen);
    if (errors == 0 && pending_coefs.size() == 0) begin
      $display("biquad_coefficient_calculator_tb passed");
    end else begin
      $display("biquad_coefficient_calculator_tb failed");
    end
    $finish;
  end

endmodule
